[rtl/core/uts_pkg.sv]
// ----------------------------------------------------------------------------
// uts_pkg
// Shared types and constants for the UTF-8 text sanitiser.
// ----------------------------------------------------------------------------
`default_nettype none

package uts_pkg;

  // Most bytes one input beat can release, and depth of the group queue
  localparam int GROUP_SLOTS = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int HOLD_DEPTH  = 3;

  localparam logic [2:0] LEN_STRAY = 3'd0;
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  localparam logic [7:0] ASCII_CTRL_MAX = 8'h1F;
  localparam logic [7:0] ASCII_DEL      = 8'h7F;

  localparam logic [20:0] CP_MIN_TWO    = 21'h000080;
  localparam logic [20:0] CP_MIN_THREE  = 21'h000800;
  localparam logic [20:0] CP_MIN_FOUR   = 21'h010000;
  localparam logic [20:0] CP_C1_MAX     = 21'h00009F;
  localparam logic [20:0] CP_SURR_LO    = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI    = 21'h00DFFF;
  localparam logic [20:0] CP_MAX        = 21'h10FFFF;
  localparam logic [20:0] CP_ZW_LO      = 21'h00200B;
  localparam logic [20:0] CP_ZW_HI      = 21'h00200F;
  localparam logic [20:0] CP_BIDI_LO    = 21'h00202A;
  localparam logic [20:0] CP_BIDI_HI    = 21'h00202E;
  localparam logic [20:0] CP_WJ_LO      = 21'h002060;
  localparam logic [20:0] CP_WJ_HI      = 21'h002064;
  localparam logic [20:0] CP_BOM        = 21'h00FEFF;

  // Bytes released by one input beat; count 0 with msg_end is a bare end marker
  typedef struct packed {
    logic [GROUP_SLOTS-1:0][7:0] bytes;
    logic [2:0]                  count;
    logic                        msg_end;
  } group_t;

endpackage

`default_nettype wire

[rtl/core/uts_front.sv]
// ----------------------------------------------------------------------------
// uts_front
// Decoder front end: holds partial UTF-8 sequences, classifies each input
// byte and emits the group of bytes that the beat releases.
// ----------------------------------------------------------------------------
`default_nettype none

module uts_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [7:0]     in_byte,
  input  wire logic           message_end,
  input  wire logic           cfg_we,
  input  wire logic           cfg_strip,
  output uts_pkg::group_t     grp,
  output logic                grp_valid
);
  import uts_pkg::*;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    priority if (b[7] == 1'b0)       lead_len = LEN_ONE;
    else if (b[7:5] == 3'b110)       lead_len = LEN_TWO;
    else if (b[7:4] == 4'b1110)      lead_len = LEN_THREE;
    else if (b[7:3] == 5'b11110)     lead_len = LEN_FOUR;
    else                             lead_len = LEN_STRAY;
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    is_sep = (b == 8'h7B) || (b == 8'h7D) || (b == 8'h3A) ||
             (b == 8'h3B) || (b == 8'h2C) || (b == 8'h2F);
  endfunction

  function automatic logic drop_cp(input logic [20:0] cp);
    drop_cp = (cp >= CP_MIN_TWO && cp <= CP_C1_MAX) ||
              (cp >= CP_ZW_LO   && cp <= CP_ZW_HI)  ||
              (cp >= CP_BIDI_LO && cp <= CP_BIDI_HI) ||
              (cp >= CP_WJ_LO   && cp <= CP_WJ_HI)  ||
              (cp == CP_BOM);
  endfunction

  logic                  strip;
  logic [7:0]            held [HOLD_DEPTH];
  logic [1:0]            held_count;
  logic [2:0]            seq_len;
  logic [14:0]           partial;

  logic                  active, is_cont, complete, grow, broken, cp_ok;
  logic                  fresh_emit, fresh_hold, ascii_drop, flush, append_b;
  logic [2:0]            fresh_len;
  logic [20:0]           cp, min_cp;
  logic [1:0]            n_held;
  logic [14:0]           fresh_code;

  always_comb begin
    active     = (seq_len != 3'd0);
    is_cont    = (in_byte[7:6] == 2'b10);
    cp         = {partial, in_byte[5:0]};
    fresh_len  = lead_len(in_byte);
    ascii_drop = (in_byte <= ASCII_CTRL_MAX) || (in_byte == ASCII_DEL) ||
                 (strip && is_sep(in_byte));
    fresh_emit = ((fresh_len == LEN_ONE) && !ascii_drop) || (fresh_len == LEN_STRAY);
    fresh_hold = (fresh_len == LEN_TWO) || (fresh_len == LEN_THREE) ||
                 (fresh_len == LEN_FOUR);

    complete = active && is_cont && (({1'b0, held_count} + 3'd1) >= seq_len);
    grow     = active && is_cont && !complete;
    broken   = active && !is_cont;

    unique case (seq_len)
      LEN_TWO:   min_cp = CP_MIN_TWO;
      LEN_THREE: min_cp = CP_MIN_THREE;
      default:   min_cp = CP_MIN_FOUR;
    endcase
    cp_ok = !(cp < min_cp) && !(cp >= CP_SURR_LO && cp <= CP_SURR_HI) &&
            !(cp > CP_MAX) && !drop_cp(cp);

    // Held bytes go out first, then possibly the current byte
    flush    = (complete && cp_ok) || (grow && message_end) || broken;
    n_held   = flush ? held_count : 2'd0;
    append_b = (complete && cp_ok) || (grow && message_end) ||
               (!is_cont || !active) && !active && (fresh_emit || (fresh_hold && message_end)) ||
               (broken && (fresh_emit || (fresh_hold && message_end)));

    for (int k = 0; k < GROUP_SLOTS; k++) begin
      if (k < HOLD_DEPTH && 2'(k) < n_held) grp.bytes[k] = held[k];
      else                                  grp.bytes[k] = in_byte;
    end
    grp.count   = {1'b0, n_held} + {2'b00, append_b};
    grp.msg_end = message_end;
    grp_valid   = accept && ((grp.count != 3'd0) || message_end);

    unique case (fresh_len)
      LEN_TWO:   fresh_code = {10'd0, in_byte[4:0]};
      LEN_THREE: fresh_code = {11'd0, in_byte[3:0]};
      default:   fresh_code = {12'd0, in_byte[2:0]};
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      strip      <= 1'b0;
      held_count <= 2'd0;
      seq_len    <= 3'd0;
      partial    <= '0;
    end else begin
      if (cfg_we) strip <= cfg_strip;
      if (accept) begin
        priority if (message_end) begin
          held_count <= 2'd0;
          seq_len    <= 3'd0;
          partial    <= '0;
        end else if (grow) begin
          held_count <= held_count + 2'd1;
          partial    <= cp[14:0];
        end else if (!is_cont && fresh_hold || !active && fresh_hold) begin
          held_count <= 2'd1;
          seq_len    <= fresh_len;
          partial    <= fresh_code;
        end else begin
          held_count <= 2'd0;
          seq_len    <= 3'd0;
          partial    <= '0;
        end
      end
    end
  end

  // Held bytes: payload only, read below held_count
  always_ff @(posedge clk) begin
    if (accept && !message_end) begin
      for (int i = 0; i < HOLD_DEPTH; i++) begin
        if (grow && held_count == 2'(i)) held[i] <= in_byte;
      end
      if ((broken || !active) && fresh_hold) held[0] <= in_byte;
    end
  end

endmodule

`default_nettype wire

[rtl/core/uts_group_fifo.sv]
// ----------------------------------------------------------------------------
// uts_group_fifo
// Short queue of byte groups between decoder and serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

module uts_group_fifo #(
  parameter int Depth = uts_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire uts_pkg::group_t wr_grp,
  output logic                full,
  input  wire logic           pop,
  output uts_pkg::group_t     rd_grp,
  output logic                nonempty
);
  import uts_pkg::*;

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);

  group_t           mem [Depth];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(Depth));
  assign nonempty = (fill != '0);
  assign rd_grp   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_grp;
  end

endmodule

`default_nettype wire

[rtl/core/uts_back.sv]
// ----------------------------------------------------------------------------
// uts_back
// Serialiser: unpacks groups one at a time into result beats, one per pop.
// ----------------------------------------------------------------------------
`default_nettype none

module uts_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire uts_pkg::group_t head,
  input  wire logic           head_valid,
  output logic                head_take,
  input  wire logic           pop,
  output logic                empty,
  output logic [7:0]          out_byte,
  output logic                byte_present,
  output logic                run_last,
  output logic                output_done
);
  import uts_pkg::*;

  group_t     cur;
  logic       busy;
  logic [1:0] idx;
  logic [2:0] eff_cnt, last_m1;
  logic       bare, is_last, advance;

  always_comb begin
    bare      = (cur.count == 3'd0);
    eff_cnt   = bare ? 3'd1 : cur.count;
    last_m1   = eff_cnt - 3'd1;
    is_last   = (idx == last_m1[1:0]);
    advance   = busy && pop;
    head_take = head_valid && (!busy || (advance && is_last));

    empty        = !busy;
    out_byte     = bare ? 8'h00 : cur.bytes[idx];
    byte_present = !bare;
    run_last     = is_last;
    output_done  = is_last && cur.msg_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else begin
      priority if (head_take) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (advance && is_last) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else if (advance) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_take) cur <= head;
  end

endmodule

`default_nettype wire

[rtl/core/utf8_text_sanitizer.sv]
// ----------------------------------------------------------------------------
// utf8_text_sanitizer
// Streaming UTF-8 filter: drops controls, format characters and invalid code
// points, passes stray and cut-off bytes raw, one byte per cycle unless full.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        in_byte, message_end
//  result    empty / pop        out_byte, byte_present, run_last, output_done
//  config    cfg_valid / ready  strip_separators
//
//  One byte accepted per cycle while the group queue has room; a result is
//  registered in the queue and then in the serialiser, which gives one
//  result beat per cycle while pop is asserted, so a byte releasing up to
//  four results holds the output while the queue takes input. Reset empties
//  the queue and clears strip mode. Either side may stall without loss.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_text_sanitizer #(
  parameter int QueueDepth = uts_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       message_end,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            byte_present,
  output logic            run_last,
  output logic            output_done,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       strip_separators
);
  import uts_pkg::*;

  group_t grp, head;
  logic   grp_push, head_valid, head_take, accept;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  uts_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .message_end (message_end),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_strip   (strip_separators),
    .grp         (grp),
    .grp_valid   (grp_push)
  );

  uts_group_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (grp_push),
    .wr_grp   (grp),
    .full     (full),
    .pop      (head_take),
    .rd_grp   (head),
    .nonempty (head_valid)
  );

  uts_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .head_take    (head_take),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .byte_present (byte_present),
    .run_last     (run_last),
    .output_done  (output_done)
  );

`ifndef NO_ASSERTIONS
  // Decoder never writes a group into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    grp_push |-> !full)
    else $error("group pushed into full queue");

  // A bare end marker is always the final beat of its message
  a_bare_is_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_present) |-> (run_last && output_done))
    else $error("bare end marker not final");

  // A run in progress keeps results on offer after a mid-run pop
  a_run_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !run_last) |=> !empty)
    else $error("run broken before its last beat");

  // Nothing on offer straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result offered after reset");
`endif

endmodule

`default_nettype wire
